[sv/frbm_pkg.sv]
`default_nettype none
package frbm_pkg;

   localparam int MAX_RULES   = 32;
   localparam int PORT_RANGES = 4;
   localparam int ADDR_RANGES = 4;
   localparam int RULE_W      = $clog2(MAX_RULES);
   localparam int PSLOT_W     = $clog2(PORT_RANGES);
   localparam int ASLOT_W     = $clog2(ADDR_RANGES);
   localparam int CNT_W       = 6;
   localparam int WALK_W      = RULE_W + 1;

   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_PORT   = 2'd1,
      KIND_ADDR   = 2'd2,
      KIND_QUERY  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      G_NONE   = 3'd0,
      G_GLOBAL = 3'd1,
      G_BYNOT  = 3'd2,
      G_RANGE  = 3'd3,
      G_EXACT  = 3'd4
   } grade_type;

   localparam logic [1:0] PMODE_EXACT = 2'd1;
   localparam logic [1:0] PMODE_NOT   = 2'd2;
   localparam logic [1:0] PROTO_ANY   = 2'd0;

   typedef struct packed {
      grade_type prog;
      grade_type endp;
      grade_type port;
      grade_type addr;
      logic      act;
      grade_type proto;
   } grades_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_READ = 2'd1,
      ST_EVAL = 2'd2,
      ST_DONE = 2'd3
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic capture;   // latch the accepted item
      logic do_write;  // perform a table write from the latched item
      logic walk_init; // clear the match and conflict flags
      logic walk_read; // issue read of current rule, advance pointer
      logic walk_eval; // grade the rule read last cycle
      logic load_out;  // move the result to the output register
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic is_query;
      logic walk_last; // pointer reached the walk length
   } sts_type;

   function automatic logic better(input grades_type a, input grades_type b);
      logic r;
      if (a.prog != b.prog)           r = a.prog > b.prog;
      else if (a.endp != b.endp)      r = a.endp > b.endp;
      else if (a.port != b.port)      r = a.port > b.port;
      else if (a.addr != b.addr)      r = a.addr > b.addr;
      else if (a.act && !b.act)       r = 1'b1;
      else if (a.proto != b.proto)    r = a.proto > b.proto;
      else                            r = 1'b0;
      return r;
   endfunction

endpackage
`default_nettype wire

[sv/frbm_ram.sv]
`default_nettype none
module frbm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

[sv/frbm_ctrl.sv]
`default_nettype none
module frbm_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   input  wire frbm_pkg::sts_type sts,
   output frbm_pkg::cmd_type     cmd
);
   import frbm_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_READ;
         end
         ST_READ: begin
            if (!sts.is_query)      state_in = ST_IDLE;
            else if (sts.walk_last) state_in = ST_DONE;
            else                    state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (sts.walk_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            cmd.capture = accept;
         end
         ST_READ: begin
            cmd.do_write  = !sts.is_query;
            cmd.walk_init = sts.is_query;
            cmd.walk_read = sts.is_query && !sts.walk_last;
         end
         ST_EVAL: begin
            cmd.walk_eval = 1'b1;
            cmd.walk_read = !sts.walk_last;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule
`default_nettype wire

[sv/frbm_dp.sv]
`default_nettype none
module frbm_dp (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire frbm_pkg::cmd_type cmd,
   output frbm_pkg::sts_type      sts,
   input  wire logic              csr_write_enable,
   input  wire logic [5:0]        csr_write_data,
   input  wire logic [1:0]        req_kind,
   input  wire logic [4:0]        req_rule_index,
   input  wire logic [1:0]        req_slot,
   input  wire logic              req_enable,
   input  wire logic [1:0]        req_prog_mode,
   input  wire logic [15:0]       req_prog_id,
   input  wire logic              req_action,
   input  wire logic [1:0]        req_protocol,
   input  wire logic [31:0]       req_range_low,
   input  wire logic [31:0]       req_range_high,
   input  wire logic [15:0]       req_test_port,
   input  wire logic [31:0]       req_test_address,
   output logic                   rsp_match_found,
   output logic [4:0]             rsp_best_rule,
   output logic                   rsp_best_action,
   output logic                   rsp_conflict_seen
);
   import frbm_pkg::*;

   localparam int HDR_W  = 2 + 16 + 1 + 2;
   localparam int PORT_W = PORT_RANGES * 32;
   localparam int ADDR_W = ADDR_RANGES * 64;

   logic [CNT_W-1:0] rule_count_ff;

   // Latched item.
   kind_type    kind_ff;
   logic [4:0]  idx_ff;
   logic [1:0]  slot_ff;
   logic        en_ff;
   logic [1:0]  pmode_ff;
   logic [15:0] pid_ff;
   logic        act_ff;
   logic [1:0]  proto_ff;
   logic [31:0] rlo_ff, rhi_ff;
   logic [15:0] tport_ff;
   logic [31:0] taddr_ff;

   // Used bits per rule, cleared by reset.
   logic [PORT_RANGES-1:0] pused_ff [MAX_RULES];
   logic [ADDR_RANGES-1:0] aused_ff [MAX_RULES];

   logic [WALK_W-1:0] ptr_ff, len_ff;
   logic [RULE_W-1:0] cur_ff;
   logic [PORT_RANGES-1:0] cur_pused_ff;
   logic [ADDR_RANGES-1:0] cur_aused_ff;

   logic              have_ff, conflict_ff;
   logic [RULE_W-1:0] best_ff;
   grades_type        bg_ff;

   // Rule storage in memories: header and full range rows per rule.
   logic              in_range;
   logic [RULE_W-1:0] widx;
   logic              hdr_we, port_we, addr_we;
   logic [HDR_W-1:0]  hdr_rd;
   logic [PORT_W-1:0] port_rd, port_wd;
   logic [ADDR_W-1:0] addr_rd, addr_wd;
   logic [RULE_W-1:0] rd_addr;

   // Ranges are kept as rows: a slot write is a read-modify-write of its row.
   // The row was read in the capture cycle at the write address.
   assign in_range = ({3'd0, idx_ff} < 8'(MAX_RULES));
   assign widx     = idx_ff[RULE_W-1:0];
   assign hdr_we   = cmd.do_write && kind_ff == KIND_HEADER && in_range;
   assign port_we  = cmd.do_write && kind_ff == KIND_PORT && in_range
                     && ({1'b0, slot_ff} < 3'(PORT_RANGES));
   assign addr_we  = cmd.do_write && kind_ff == KIND_ADDR && in_range
                     && ({1'b0, slot_ff} < 3'(ADDR_RANGES));
   assign rd_addr  = cmd.capture ? req_rule_index[RULE_W-1:0] : ptr_ff[RULE_W-1:0];

   always_comb begin
      port_wd = port_rd;
      addr_wd = addr_rd;
      port_wd[slot_ff[PSLOT_W-1:0]*32 +: 32] = {rhi_ff[15:0], rlo_ff[15:0]};
      addr_wd[slot_ff[ASLOT_W-1:0]*64 +: 64] = {rhi_ff, rlo_ff};
   end

   frbm_ram #(.WIDTH(HDR_W), .DEPTH(MAX_RULES)) u_hdr (
      .clock, .wr_en(hdr_we), .wr_addr(widx),
      .wr_data({pmode_ff, pid_ff, act_ff, proto_ff}),
      .rd_addr, .rd_data(hdr_rd));
   frbm_ram #(.WIDTH(PORT_W), .DEPTH(MAX_RULES)) u_port (
      .clock, .wr_en(port_we), .wr_addr(widx), .wr_data(port_wd),
      .rd_addr, .rd_data(port_rd));
   frbm_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_RULES)) u_addr (
      .clock, .wr_en(addr_we), .wr_addr(widx), .wr_data(addr_wd),
      .rd_addr, .rd_data(addr_rd));

   // The pointer is cleared at capture, so in the first walk cycle this is
   // the test for an empty walk.
   assign sts.is_query  = (kind_ff == KIND_QUERY);
   assign sts.walk_last = (ptr_ff == len_ff);

   // Grading of the rule read last cycle.
   grades_type g;
   logic       hit;
   logic [1:0]  r_pmode, r_proto;
   logic [15:0] r_pid;
   logic        r_act;

   function automatic grade_type range_grade(input logic [16*32-1:0] lo,
         input logic [16*32-1:0] hi, input logic [15:0] used, input int n,
         input logic [31:0] t);
      logic any, found;
      logic [31:0] blo, bhi;
      grade_type gr;
      any = 1'b0; found = 1'b0; blo = '0; bhi = '0;
      for (int s = 0; s < n; s++) begin
         if (used[s]) begin
            any = 1'b1;
            if (hi[s*32 +: 32] >= t && (!found || hi[s*32 +: 32] <= bhi)) begin
               found = 1'b1;
               bhi = hi[s*32 +: 32];
               blo = lo[s*32 +: 32];
            end
         end
      end
      if (!any)                     gr = G_GLOBAL;
      else if (t == '0)             gr = G_EXACT;
      else if (!found || t < blo)   gr = G_NONE;
      else if (bhi == blo)          gr = G_EXACT;
      else                          gr = G_RANGE;
      return gr;
   endfunction

   always_comb begin
      logic [16*32-1:0] plo, phi, alo, ahi;
      logic [15:0] pu, au;
      logic eq;
      {r_pmode, r_pid, r_act, r_proto} = hdr_rd;
      plo = '0; phi = '0; alo = '0; ahi = '0; pu = '0; au = '0;
      for (int s = 0; s < PORT_RANGES; s++) begin
         plo[s*32 +: 32] = {16'd0, port_rd[s*32 +: 16]};
         phi[s*32 +: 32] = {16'd0, port_rd[s*32+16 +: 16]};
         pu[s] = cur_pused_ff[s];
      end
      for (int s = 0; s < ADDR_RANGES; s++) begin
         alo[s*32 +: 32] = addr_rd[s*64 +: 32];
         ahi[s*32 +: 32] = addr_rd[s*64+32 +: 32];
         au[s] = cur_aused_ff[s];
      end
      eq = (r_pid == pid_ff);
      hit = 1'b1;
      if (r_pmode == PMODE_EXACT)    g.prog = (!en_ff || eq)  ? G_EXACT : G_NONE;
      else if (r_pmode == PMODE_NOT) g.prog = (!en_ff || !eq) ? G_BYNOT : G_NONE;
      else                           g.prog = G_GLOBAL;
      g.port = range_grade(plo, phi, pu, PORT_RANGES, {16'd0, tport_ff});
      g.addr = range_grade(alo, ahi, au, ADDR_RANGES, taddr_ff);
      if (r_proto == PROTO_ANY) g.proto = G_GLOBAL;
      else begin
         g.proto = G_EXACT;
         if (!(proto_ff == PROTO_ANY || proto_ff == r_proto)) hit = 1'b0;
      end
      if (g.prog == G_NONE || g.port == G_NONE || g.addr == G_NONE) hit = 1'b0;
      g.endp = G_NONE;
      if (g.addr > G_GLOBAL && g.port > G_GLOBAL)
         g.endp = (g.addr > g.port) ? g.addr : g.port;
      g.act = r_act;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff  <= kind_type'(req_kind);
         idx_ff   <= req_rule_index;
         slot_ff  <= req_slot;
         en_ff    <= req_enable;
         pmode_ff <= req_prog_mode;
         pid_ff   <= req_prog_id;
         act_ff   <= req_action;
         proto_ff <= req_protocol;
         rlo_ff   <= req_range_low;
         rhi_ff   <= req_range_high;
         tport_ff <= req_test_port;
         taddr_ff <= req_test_address;
      end
      if (cmd.walk_read) begin
         cur_ff       <= ptr_ff[RULE_W-1:0];
         cur_pused_ff <= pused_ff[ptr_ff[RULE_W-1:0]];
         cur_aused_ff <= aused_ff[ptr_ff[RULE_W-1:0]];
      end
      if (cmd.load_out) begin
         rsp_match_found   <= have_ff;
         rsp_best_rule     <= have_ff ? 5'(best_ff) : 5'd0;
         rsp_best_action   <= have_ff ? bg_ff.act : 1'b0;
         rsp_conflict_seen <= conflict_ff;
      end
      if (cmd.walk_eval && hit) begin
         if (!have_ff || better(g, bg_ff)) begin
            best_ff <= cur_ff;
            bg_ff   <= g;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rule_count_ff <= '0;
         ptr_ff        <= '0;
         len_ff        <= '0;
         have_ff       <= 1'b0;
         conflict_ff   <= 1'b0;
         for (int r = 0; r < MAX_RULES; r++) begin
            pused_ff[r] <= '0;
            aused_ff[r] <= '0;
         end
      end else begin
         if (csr_write_enable) rule_count_ff <= csr_write_data;
         if (hdr_we) begin
            pused_ff[widx] <= '0;
            aused_ff[widx] <= '0;
         end
         if (port_we) pused_ff[widx][slot_ff[PSLOT_W-1:0]] <= en_ff;
         if (addr_we) aused_ff[widx][slot_ff[ASLOT_W-1:0]] <= en_ff;
         if (cmd.capture) begin
            ptr_ff <= '0;
            len_ff <= ({1'b0, rule_count_ff} > 7'(MAX_RULES))
                      ? WALK_W'(MAX_RULES) : WALK_W'(rule_count_ff);
         end
         if (cmd.walk_init) begin
            have_ff     <= 1'b0;
            conflict_ff <= 1'b0;
         end
         if (cmd.walk_read) ptr_ff <= ptr_ff + 1'b1;
         if (cmd.walk_eval && hit) begin
            if (!have_ff || better(g, bg_ff)) have_ff <= 1'b1;
            else if (!better(bg_ff, g)) begin
               have_ff     <= 1'b0;
               conflict_ff <= 1'b1;
            end
         end
      end
   end
endmodule
`default_nettype wire

[sv/firewall_rule_best_match_unit.sv]
// Channel   Direction  Handshake              Payload
// req_      in         req_valid/req_ready    kind, rule, slot, ranges, test fields
// rsp_      out        rsp_valid/rsp_ready    match_found, best_rule, best_action, conflict
// csr_      in         csr_write_enable       rule_count (6 bits)
//
// A write item is captured, then the header or range row is written
// (range slots use a read-modify-write of the rule's row, read at capture).
// A query walks rule_count rules, capped at MAX_RULES, one rule per cycle through
// the registered read ports of the rule memories, then the result is loaded.
// Synchronous active-high reset clears control and the range used bits.
// A held result stalls only the final load; the unit takes one item at a time.
`default_nettype none
module firewall_rule_best_match_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [5:0]  csr_write_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_kind,
   input  wire logic [4:0]  req_rule_index,
   input  wire logic [1:0]  req_slot,
   input  wire logic        req_enable,
   input  wire logic [1:0]  req_prog_mode,
   input  wire logic [15:0] req_prog_id,
   input  wire logic        req_action,
   input  wire logic [1:0]  req_protocol,
   input  wire logic [31:0] req_range_low,
   input  wire logic [31:0] req_range_high,
   input  wire logic [15:0] req_test_port,
   input  wire logic [31:0] req_test_address,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_match_found,
   output logic [4:0]       rsp_best_rule,
   output logic             rsp_best_action,
   output logic             rsp_conflict_seen
);
   import frbm_pkg::*;

   // Commands from the controller and status from the datapath.
   cmd_type cmd;
   sts_type sts;

   frbm_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .sts, .cmd);

   frbm_dp u_dp (
      .clock, .reset, .cmd, .sts, .csr_write_enable, .csr_write_data,
      .req_kind, .req_rule_index, .req_slot, .req_enable, .req_prog_mode,
      .req_prog_id, .req_action, .req_protocol, .req_range_low,
      .req_range_high, .req_test_port, .req_test_address,
      .rsp_match_found, .rsp_best_rule, .rsp_best_action, .rsp_conflict_seen);
endmodule
`default_nettype wire

[sv/frbm_checker.sv]
`default_nettype none
module frbm_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_match_found,
   input wire logic [4:0] rsp_best_rule,
   input wire logic       rsp_best_action
);
   a_no_match_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_match_found |-> rsp_best_rule == 5'd0 && !rsp_best_action)
      else $error("no-match result with nonzero rule or action");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_best_rule))
      else $error("result changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("accepted two items back to back");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");
endmodule

bind firewall_rule_best_match_unit frbm_checker u_frbm_checker (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
   .rsp_match_found, .rsp_best_rule, .rsp_best_action);
`default_nettype wire
